// ===== src/mm_pkg.sv =====
// Package for the matrix multiply block: payload types, command and status
// structs, opcodes and register indexes. Depends on nothing.
`default_nettype none

package mm_pkg;

    localparam int DIM_LIMIT  = 8;
    localparam int ST_ADDR_W  = $clog2(DIM_LIMIT * DIM_LIMIT);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int ELEM_W     = 32;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int FRAC_W     = 16;

    localparam logic [1:0] OP_WR_A    = 2'd0;
    localparam logic [1:0] OP_WR_B    = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd2;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [2:0]               row_index;
        logic [2:0]               col_index;
        logic signed [ELEM_W-1:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]               out_row;
        logic [2:0]               out_col;
        logic signed [ELEM_W-1:0] product_value;
        logic                     saturated;
        logic                     last;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_item;

    typedef struct packed {
        logic                     wr_a;
        logic                     wr_b;
        logic [ST_ADDR_W-1:0]     wr_addr;
        logic signed [ELEM_W-1:0] wr_data;
        logic                     rd_valid;
        logic                     rd_first;
        logic                     rd_last;
        logic [ST_ADDR_W-1:0]     rd_addr_a;
        logic [ST_ADDR_W-1:0]     rd_addr_b;
        logic [2:0]               row;
        logic [2:0]               col;
        logic                     last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
        logic res_done;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== src/mm_chan_if.sv =====
// Valid/ready channel interface carrying one payload of a given type.
// Used for the input, output and configuration channels; no dependencies.
`default_nettype none

interface mm_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/matrix_multiply.sv =====
// Top level of the matrix multiply block: controller and datapath.
// Depends on mm_pkg, mm_chan_if, mm_ctrl and mm_datapath.
//
// Usage: i_in takes load and compute items, i_cfg writes the rows_a,
// inner_size and cols_b registers (index 0, 1, 2), o_out returns product
// elements. Every channel moves one item per transfer (valid and ready high).
// Loads are taken while no walk runs, and then stream at one transfer per cycle.
// A compute transfer starts a walk over all rows_a * cols_b product elements
// in row-major order; the last element carries last. Each element is read
// over the inner dimension through the single read port of each store and
// then passes the multiply, accumulate and rounding stages into the output
// register before the walk starts the next element. Input ready stays low
// for the whole walk.
// Results are held in an output register; while the receiver stalls, the
// walk waits before starting the next element, so nothing is lost.
// Reset returns the controller to idle, clears the pipeline valids and the
// output valid and sets the dimension registers to 8. Store contents are not cleared.
`default_nettype none

module matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mm_chan_if.sink   i_in,
    mm_chan_if.source o_out,
    mm_chan_if.sink   i_cfg
);
    import mm_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    mm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    mm_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

// ===== src/mm_ctrl.sv =====
// Controller of the matrix multiply block: configuration registers, load
// decoding and the walk over product elements. Depends on mm_pkg, mm_chan_if.
`default_nettype none

module mm_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mm_chan_if.sink            i_in,
    mm_chan_if.sink            i_cfg,
    input  mm_pkg::t_dp_status i_status,
    output mm_pkg::t_dp_cmd    o_cmd
);
    import mm_pkg::*;

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WAIT  = 2'd1;
    localparam logic [1:0] S_ISSUE = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [IW-1:0]         r_i, n_i;
    logic [IW-1:0]         r_j, n_j;
    logic [IW-1:0]         r_t, n_t;
    logic [IW-1:0]         r_m1, n_m1;
    logic [IW-1:0]         r_k1, n_k1;
    logic [IW-1:0]         r_n1, n_n1;
    logic [CFG_DATA_W-1:0] r_rows_a;
    logic [CFG_DATA_W-1:0] r_inner;
    logic [CFG_DATA_W-1:0] r_cols_b;

    logic w_in_xfer;
    logic w_cfg_xfer;
    logic w_in_range;
    logic w_last_elem;

    function automatic logic [IW-1:0] dim_m1(input logic [CFG_DATA_W-1:0] raw);
        logic [CFG_DATA_W-1:0] v;
        v = raw;
        if (raw == '0) begin
            v = CFG_DATA_W'(1);
        end else if (raw > CFG_DATA_W'(MAX_DIM)) begin
            v = CFG_DATA_W'(MAX_DIM);
        end
        v = v - CFG_DATA_W'(1);
        return v[IW-1:0];
    endfunction

    assign i_in.ready  = i_rst_n && (r_state == S_IDLE);
    assign i_cfg.ready = i_rst_n;
    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign w_cfg_xfer  = i_cfg.valid && i_cfg.ready;
    assign w_in_range  = ({1'b0, i_in.payload.row_index} < 4'(MAX_DIM))
                      && ({1'b0, i_in.payload.col_index} < 4'(MAX_DIM));
    assign w_last_elem = (r_i == r_m1) && (r_j == r_n1);

    always_comb begin
        o_cmd.wr_a      = w_in_xfer && w_in_range && (i_in.payload.opcode == OP_WR_A);
        o_cmd.wr_b      = w_in_xfer && w_in_range && (i_in.payload.opcode == OP_WR_B);
        o_cmd.wr_addr   = ST_ADDR_W'(int'(i_in.payload.row_index) * MAX_DIM
                                     + int'(i_in.payload.col_index));
        o_cmd.wr_data   = i_in.payload.element_value;
        o_cmd.rd_valid  = (r_state == S_ISSUE);
        o_cmd.rd_first  = (r_t == '0);
        o_cmd.rd_last   = (r_t == r_k1);
        o_cmd.rd_addr_a = ST_ADDR_W'(int'(r_i) * MAX_DIM + int'(r_t));
        o_cmd.rd_addr_b = ST_ADDR_W'(int'(r_t) * MAX_DIM + int'(r_j));
        o_cmd.row       = 3'(r_i);
        o_cmd.col       = 3'(r_j);
        o_cmd.last      = w_last_elem;
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_t     = r_t;
        n_m1    = r_m1;
        n_k1    = r_k1;
        n_n1    = r_n1;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer && (i_in.payload.opcode == OP_COMPUTE)) begin
                    n_state = S_WAIT;
                    n_i     = '0;
                    n_j     = '0;
                    n_m1    = dim_m1(r_rows_a);
                    n_k1    = dim_m1(r_inner);
                    n_n1    = dim_m1(r_cols_b);
                end
            end
            S_WAIT: begin
                if (!i_status.out_full) begin
                    n_state = S_ISSUE;
                    n_t     = '0;
                end
            end
            S_ISSUE: begin
                if (r_t == r_k1) begin
                    n_state = S_DRAIN;
                end else begin
                    n_t = r_t + IW'(1);
                end
            end
            S_DRAIN: begin
                if (i_status.res_done) begin
                    if (w_last_elem) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_WAIT;
                        if (r_j == r_n1) begin
                            n_j = '0;
                            n_i = r_i + IW'(1);
                        end else begin
                            n_j = r_j + IW'(1);
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rows_a <= CFG_DATA_W'(8);
            r_inner  <= CFG_DATA_W'(8);
            r_cols_b <= CFG_DATA_W'(8);
        end else begin
            r_state <= n_state;
            if (w_cfg_xfer) begin
                unique case (i_cfg.payload.index)
                    REG_ROWS_A: r_rows_a <= i_cfg.payload.data;
                    REG_INNER:  r_inner  <= i_cfg.payload.data;
                    REG_COLS_B: r_cols_b <= i_cfg.payload.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i  <= n_i;
        r_j  <= n_j;
        r_t  <= n_t;
        r_m1 <= n_m1;
        r_k1 <= n_k1;
        r_n1 <= n_n1;
    end

endmodule

`default_nettype wire

// ===== src/mm_datapath.sv =====
// Datapath of the matrix multiply block: A and B element stores, the
// multiply-accumulate pipeline, rounding, saturation and the output register.
// Depends on mm_pkg and mm_chan_if.
`default_nettype none

module mm_datapath #(
    parameter int MAX_DIM = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mm_pkg::t_dp_cmd    i_cmd,
    output mm_pkg::t_dp_status o_status,
    mm_chan_if.source          o_out
);
    import mm_pkg::*;

    localparam int Depth = MAX_DIM * MAX_DIM;
    localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int QW    = ACC_W - FRAC_W;
    localparam logic signed [ACC_W-1:0] RoundHalf = ACC_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [ELEM_W-1:0] ElemMax = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ELEM_W-1:0] ElemMin = {1'b1, {(ELEM_W-1){1'b0}}};

    logic signed [ELEM_W-1:0] r_a_mem [Depth];
    logic signed [ELEM_W-1:0] r_b_mem [Depth];

    logic signed [ELEM_W-1:0] r_a_rd;
    logic signed [ELEM_W-1:0] r_b_rd;
    logic                     r_v1, r_f1, r_l1;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic                     r_v2, r_f2, r_l2;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic                     r_v3;
    logic                     r_out_valid;
    t_out_item                r_out_data;
    t_out_item                n_out_data;

    logic signed [ACC_W-1:0]  w_rnd;
    logic [QW-1:0]            w_q;
    logic                     w_fits;

    assign n_prod = r_a_rd * r_b_rd;
    assign n_acc  = r_f2 ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);

    assign w_rnd  = r_acc + RoundHalf;
    assign w_q    = w_rnd[ACC_W-1:FRAC_W];
    assign w_fits = (w_q[QW-1:ELEM_W-1] == '0) || (w_q[QW-1:ELEM_W-1] == '1);

    always_comb begin
        n_out_data.out_row       = i_cmd.row;
        n_out_data.out_col       = i_cmd.col;
        n_out_data.last          = i_cmd.last;
        n_out_data.saturated     = !w_fits;
        if (w_fits) begin
            n_out_data.product_value = w_q[ELEM_W-1:0];
        end else begin
            n_out_data.product_value = w_q[QW-1] ? ElemMin : ElemMax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_a_mem[i_cmd.wr_addr[AW-1:0]] <= i_cmd.wr_data;
        end
        if (i_cmd.wr_b) begin
            r_b_mem[i_cmd.wr_addr[AW-1:0]] <= i_cmd.wr_data;
        end
        r_a_rd <= r_a_mem[i_cmd.rd_addr_a[AW-1:0]];
        r_b_rd <= r_b_mem[i_cmd.rd_addr_b[AW-1:0]];
        r_f1   <= i_cmd.rd_first;
        r_l1   <= i_cmd.rd_last;
        r_prod <= n_prod;
        r_f2   <= r_f1;
        r_l2   <= r_l1;
        if (r_v2) begin
            r_acc <= n_acc;
        end
        if (r_v3) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && r_l2;
            if (r_v3) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.payload     = r_out_data;
    assign o_status.out_full = r_out_valid;
    assign o_status.res_done = r_v3;

endmodule

`default_nettype wire

// ===== src/mm_checker.sv =====
// Port-level checker for the matrix multiply block and its bind to the top.
// Depends on mm_pkg and matrix_multiply.
`default_nettype none

module mm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [1:0]        i_in_opcode,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input mm_pkg::t_out_item i_out_payload
);
    import mm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("output changed while stalled");

    a_busy_after_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_opcode == OP_COMPUTE) |=> !i_in_ready)
        else $error("input ready right after a compute transfer");

    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_payload.last |-> !i_in_ready)
        else $error("input ready while a product run is unfinished");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_payload.saturated |->
            (i_out_payload.product_value == 32'sh7FFF_FFFF)
            || (i_out_payload.product_value == 32'sh8000_0000))
        else $error("saturated flag without a clipped value");

endmodule

bind matrix_multiply mm_checker u_mm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_opcode   (i_in.payload.opcode),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

`default_nettype wire
